/* design/clbr_pkg.sv */
// ----------------------------------------------------------------------------
// clbr_pkg
// Shared types and constants for the capacity-limited BFS route block.
// ----------------------------------------------------------------------------
package clbr_pkg;

  localparam int NODE_W = 4;
  localparam int MAX_NODES = 16;
  localparam int CAP_IN_W = 8;
  localparam int LOAD_W = 12;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [NODE_W-1:0]   from_node;
    logic [NODE_W-1:0]   to_node;
    logic [CAP_IN_W-1:0] edge_capacity;
    logic                edge_present;
    logic [LOAD_W-1:0]   truck_load;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] path_node;
    logic [NODE_W-1:0] hop_count;
    logic              last;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;    // latch input item
    logic tbl_write;  // write edge entry
    logic init;       // start search, clear marks
    logic pop;        // dequeue current node
    logic rd_issue;   // issue table read for (cur, nb)
    logic scan;       // evaluate returned entry
    logic walk_init;  // begin path walk from dst
    logic walk_step;  // step path walk toward start
    logic emit_init;  // set emission index
    logic emit_step;  // advance emission index
  } ctl_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_query;
    logic nodes_ok;
    logic queue_empty;
    logic nb_last;
    logic dst_visited;
    logic walk_done;
    logic emit_last;
  } dp_stat_t;

endpackage

/* design/clbr_stream_if.sv */
// ----------------------------------------------------------------------------
// clbr_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface clbr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* design/capacity_limited_bfs_route.sv */
// Edge write: capture, then table write. Query: BFS scan, path walk, result emission.
// One item at a time; the BFS scan is limited by the single edge-table read port.
// Reset: synchronous active-low; control, visited marks and queue cleared.
//   After reset a sweep clears every edge-table entry; no item is taken meanwhile.
// ----------------------------------------------------------------------------
// capacity_limited_bfs_route
// Directed edge table with capacity-limited breadth-first route search.
// ----------------------------------------------------------------------------
module capacity_limited_bfs_route #(
  parameter int NODE_COUNT = 16,
  parameter int CAPACITY_BITS = 8
) (
  input logic clk,
  input logic rst_n,
  clbr_stream_if.sink   in_ch,
  clbr_stream_if.source out_ch
);
  clbr_pkg::ctl_cmd_t  cmd, cmd_dp;
  clbr_pkg::dp_stat_t  stat;
  clbr_pkg::out_item_t out_item;
  clbr_pkg::in_item_t  in_mux;
  logic                in_ready_c;
  logic [8:0]          clr_r;
  logic                clearing;

  // sweep runs past the last entry: each table write uses the entry captured the cycle before
  assign clearing = (clr_r != 9'd257);

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (clearing) clr_r <= clr_r + 1'b1;
  end

  clbr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid && !clearing),
    .in_ready (in_ready_c),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready_c && !clearing;

  always_comb begin
    cmd_dp = cmd;
    in_mux = in_ch.payload;
    if (clearing) begin
      cmd_dp.capture      = 1'b1;
      cmd_dp.tbl_write    = 1'b1;
      in_mux.cmd          = clbr_pkg::CMD_WRITE;
      in_mux.edge_present = 1'b0;
      in_mux.from_node    = clr_r[7:4];
      in_mux.to_node      = clr_r[3:0];
    end
  end

  clbr_datapath #(
    .NODE_COUNT   (NODE_COUNT),
    .CAPACITY_BITS(CAPACITY_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_mux),
    .cmd     (cmd_dp),
    .stat    (stat),
    .out_item(out_item)
  );

  assign out_ch.payload = out_item;

`ifndef NO_ASSERTIONS
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input taken during emission");
  a_no_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ch.ready) else $error("input taken during table clear");
  a_nf_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.payload.found) |->
      (out_ch.payload.last && out_ch.payload.path_node == '0))
    else $error("not-found result malformed");
`endif
endmodule

/* design/clbr_datapath.sv */
// ----------------------------------------------------------------------------
// clbr_datapath
// Edge table memory, visited marks, predecessor/distance, queue, path stack.
// ----------------------------------------------------------------------------
module clbr_datapath #(
  parameter int NODE_COUNT = 16,
  parameter int CAPACITY_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  clbr_pkg::in_item_t    in_item,
  input  clbr_pkg::ctl_cmd_t    cmd,
  output clbr_pkg::dp_stat_t    stat,
  output clbr_pkg::out_item_t   out_item
);
  localparam int NW = clbr_pkg::NODE_W;
  localparam int NLIM = (NODE_COUNT < clbr_pkg::MAX_NODES) ? NODE_COUNT : clbr_pkg::MAX_NODES;
  localparam int CW = CAPACITY_BITS;
  localparam int PW = CW + 4;

  clbr_pkg::in_item_t item_r;

  logic [CW:0] mem [0:255];
  logic [CW:0] rd_data_r;

  logic [clbr_pkg::MAX_NODES-1:0] visited_r;
  logic [NW-1:0] pred_r [0:clbr_pkg::MAX_NODES-1];
  logic [NW-1:0] dist_r [0:clbr_pkg::MAX_NODES-1];
  logic [NW-1:0] queue_r [0:clbr_pkg::MAX_NODES-1];
  logic [NW:0]   head_r, tail_r;
  logic [NW-1:0] cur_r, nb_r, nb_rd_r;
  logic [NW-1:0] stack_r [0:clbr_pkg::MAX_NODES-1];
  logic [NW:0]   len_r;
  logic [NW-1:0] walk_r;
  logic [NW-1:0] idx_r;
  logic [NW-1:0] hops_r;
  logic          found_r;

  logic [PW-1:0] cap_x10;
  logic          usable;
  logic [CW-1:0] cap_in;

  assign cap_in  = CW'(item_r.edge_capacity);
  assign cap_x10 = {1'b0, rd_data_r[CW-1:0], 3'b000} + {3'b000, rd_data_r[CW-1:0], 1'b0};
  assign usable  = rd_data_r[CW] && !visited_r[nb_rd_r] &&
                   (32'(cap_x10) >= 32'(item_r.truck_load));

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_item;
    if (cmd.tbl_write)
      mem[{item_r.from_node, item_r.to_node}] <=
        item_r.edge_present ? {1'b1, cap_in} : '0;
    if (cmd.rd_issue) begin
      rd_data_r <= mem[{cur_r, nb_r}];
      nb_rd_r   <= nb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
      head_r    <= '0;
      tail_r    <= '0;
    end else if (cmd.init) begin
      visited_r <= {{(clbr_pkg::MAX_NODES-1){1'b0}}, 1'b1} << item_r.from_node;
      queue_r[0] <= item_r.from_node;
      pred_r[item_r.from_node] <= item_r.from_node;
      dist_r[item_r.from_node] <= '0;
      head_r <= '0;
      tail_r <= (NW+1)'(1);
    end else begin
      if (cmd.pop) begin
        cur_r  <= queue_r[head_r[NW-1:0]];
        head_r <= head_r + 1'b1;
        nb_r   <= '0;
      end
      if (cmd.rd_issue) nb_r <= nb_r + 1'b1;
      if (cmd.scan && usable) begin
        visited_r[nb_rd_r] <= 1'b1;
        pred_r[nb_rd_r]    <= cur_r;
        dist_r[nb_rd_r]    <= dist_r[cur_r] + 1'b1;
        queue_r[tail_r[NW-1:0]] <= nb_rd_r;
        tail_r <= tail_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      walk_r  <= item_r.to_node;
      len_r   <= '0;
      hops_r  <= dist_r[item_r.to_node];
      found_r <= 1'b1;
    end else if (cmd.walk_step) begin
      stack_r[len_r[NW-1:0]] <= walk_r;
      len_r  <= len_r + 1'b1;
      walk_r <= pred_r[walk_r];
    end else if (cmd.capture) begin
      found_r <= 1'b0;
      hops_r  <= '0;
      len_r   <= '0;
    end
    if (cmd.emit_init) idx_r <= NW'(len_r - 1'b1);
    else if (cmd.emit_step) idx_r <= idx_r - 1'b1;
  end

  assign stat.is_query    = (item_r.cmd == clbr_pkg::CMD_QUERY);
  assign stat.nodes_ok    = (32'(item_r.from_node) < NLIM) && (32'(item_r.to_node) < NLIM);
  assign stat.queue_empty = (head_r == tail_r);
  assign stat.nb_last     = (32'(nb_r) == NLIM - 1);
  assign stat.dst_visited = visited_r[item_r.to_node];
  assign stat.walk_done   = (walk_r == item_r.from_node) || (len_r == (NW+1)'(15));
  assign stat.emit_last   = (idx_r == '0);

  assign out_item.found     = found_r;
  assign out_item.path_node = found_r ? stack_r[idx_r] : '0;
  assign out_item.hop_count = found_r ? hops_r : '0;
  assign out_item.last      = !found_r || (idx_r == '0);
endmodule

/* design/clbr_ctrl.sv */
// ----------------------------------------------------------------------------
// clbr_ctrl
// Sequencer for edge writes, BFS scan, path walk and result emission.
// ----------------------------------------------------------------------------
module clbr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  clbr_pkg::dp_stat_t stat,
  output clbr_pkg::ctl_cmd_t cmd
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DEC   = 10'b0000000010,
    S_POP   = 10'b0000000100,
    S_READ  = 10'b0000001000,
    S_SCAN  = 10'b0000010000,
    S_CHECK = 10'b0000100000,
    S_WALK  = 10'b0001000000,
    S_EMITI = 10'b0010000000,
    S_EMIT  = 10'b0100000000,
    S_NF    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   more_r, more_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      more_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      more_r  <= more_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    more_nxt  = more_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_EMIT) || (state_r == S_NF);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        if (!stat.is_query) begin
          cmd.tbl_write = stat.nodes_ok;
          state_nxt     = S_IDLE;
        end else if (!stat.nodes_ok) begin
          state_nxt = S_NF;
        end else begin
          cmd.init  = 1'b1;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (stat.queue_empty) begin
          state_nxt = S_CHECK;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        more_nxt     = !stat.nb_last;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = more_r ? S_READ : S_POP;
      end
      S_CHECK: begin
        if (stat.dst_visited) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK;
        end else begin
          state_nxt = S_NF;
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_done) state_nxt = S_EMITI;
      end
      S_EMITI: begin
        cmd.emit_init = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          cmd.emit_step = 1'b1;
          if (stat.emit_last) state_nxt = S_IDLE;
        end
      end
      S_NF: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
